### sv/cllm_pkg.sv
// shared constants, codes and control types for the linked-list manager
package cllm_pkg;

  localparam int NODES_DEF   = 8;
  localparam int MAX_RESULTS = 8;

  localparam int FUNC_W = 2;
  localparam int HEAD_W = 3;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE = 2'd0,
    FN_INSERT = 2'd1,
    FN_READ   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CREATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_ELEMENT  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RD_FREE = 2'd0,
    RD_HEAD = 2'd1,
    RD_LINK = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NEW_NULL = 2'd0,
    WR_NEW_LINK = 2'd1,
    WR_HEAD_NEW = 2'd2
  } wr_sel_t;

  typedef struct packed {
    logic    cap_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    new_ld;
    logic    free_ld;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    elem_we;
    logic    cur_ld;
    logic    count_clr;
    logic    count_inc;
    logic    out_ld;
    status_t out_kind;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  head_oor;
    logic  free_null;
    logic  rd_null;
    logic  elem_last;
    logic  out_free;
  } sts_t;

endpackage

### sv/cllm_if.sv
// valid/ready channel interfaces for operations and results
interface cllm_in_if;
  logic                        valid;
  logic                        ready;
  logic [cllm_pkg::FUNC_W-1:0] func;
  logic [cllm_pkg::HEAD_W-1:0] list_head;
  logic [cllm_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output func, output list_head, output data_byte,
                  input ready);
  modport sink   (input valid, input func, input list_head, input data_byte,
                  output ready);
endinterface

interface cllm_out_if;
  logic                        valid;
  logic                        ready;
  logic [cllm_pkg::STAT_W-1:0] status;
  logic [cllm_pkg::IDX_W-1:0]  node_index;
  logic [cllm_pkg::BYTE_W-1:0] elem_byte;
  logic                        last;

  modport source (output valid, output status, output node_index, output elem_byte,
                  output last, input ready);
  modport sink   (input valid, input status, input node_index, input elem_byte,
                  input last, output ready);
endinterface

### sv/cllm_dp.sv
// datapath: node store, free-list head, walk cursor and result register
module cllm_dp #(
  parameter int NODES = cllm_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cllm_pkg::cmd_t              cmd,
  output cllm_pkg::sts_t              sts,
  input  logic [cllm_pkg::FUNC_W-1:0] in_func,
  input  logic [cllm_pkg::HEAD_W-1:0] in_list_head,
  input  logic [cllm_pkg::BYTE_W-1:0] in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cllm_pkg::STAT_W-1:0] out_status,
  output logic [cllm_pkg::IDX_W-1:0]  out_node_index,
  output logic [cllm_pkg::BYTE_W-1:0] out_elem_byte,
  output logic                        out_last
);

  localparam int IW    = $clog2(NODES);
  localparam int LW    = IW + 1;
  localparam int CAP   = (NODES < cllm_pkg::MAX_RESULTS) ? NODES : cllm_pkg::MAX_RESULTS;
  localparam int CW    = $clog2(CAP + 1);
  localparam int IDX_W = cllm_pkg::IDX_W;
  localparam int BW    = cllm_pkg::BYTE_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

  // latched operation
  cllm_pkg::func_t             func_r;
  logic [cllm_pkg::HEAD_W-1:0] head_r;
  logic [BW-1:0]               data_r;

  logic [LW-1:0] free_head_r;
  logic [IW-1:0] new_r;
  logic [IW-1:0] cur_r;
  logic [CW-1:0] count_r;

  // node store
  logic [LW-1:0] link_mem [NODES];
  logic [BW-1:0] elem_mem [NODES];
  logic [NODES-1:0] lvalid_r;
  logic [LW-1:0] link_q;
  logic [BW-1:0] elem_q;
  logic          lvalid_q;
  logic [IW-1:0] laddr_q;

  logic [LW-1:0] rd_link;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [LW-1:0] wdata;
  logic          rd_null;

  // result register
  logic                        out_valid_r;
  logic [cllm_pkg::STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]            out_idx_r;
  logic [BW-1:0]               out_byte_r;
  logic                        out_last_r;

  // an entry never written still holds its reset link, i plus one
  assign rd_link = lvalid_q ? link_q : (LW'(laddr_q) + LW'(1));
  assign rd_null = (rd_link >= NULL_LINK);

  always_comb begin
    case (cmd.rd_sel)
      cllm_pkg::RD_FREE: raddr = IW'(free_head_r);
      cllm_pkg::RD_HEAD: raddr = IW'(head_r);
      cllm_pkg::RD_LINK: raddr = IW'(rd_link);
      default:           raddr = IW'(free_head_r);
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      cllm_pkg::WR_NEW_NULL: begin
        waddr = new_r;
        wdata = NULL_LINK;
      end
      cllm_pkg::WR_NEW_LINK: begin
        waddr = new_r;
        wdata = rd_link;
      end
      cllm_pkg::WR_HEAD_NEW: begin
        waddr = IW'(head_r);
        wdata = LW'(new_r);
      end
      default: begin
        waddr = new_r;
        wdata = NULL_LINK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      link_mem[waddr] <= wdata;
    end
    if (cmd.elem_we) begin
      elem_mem[new_r] <= data_r;
    end
    if (cmd.rd_en) begin
      link_q  <= link_mem[raddr];
      elem_q  <= elem_mem[raddr];
      laddr_q <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r <= '0;
      lvalid_q <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        lvalid_r[waddr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        lvalid_q <= lvalid_r[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      func_r <= cllm_pkg::func_t'(in_func);
      head_r <= in_list_head;
      data_r <= in_data_byte;
    end
    if (cmd.new_ld) begin
      new_r <= IW'(free_head_r);
    end
    if (cmd.cur_ld) begin
      cur_r <= IW'(rd_link);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      count_r     <= '0;
    end else begin
      if (cmd.free_ld) begin
        free_head_r <= rd_link;
      end
      if (cmd.count_clr) begin
        count_r <= '0;
      end else if (cmd.count_inc) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status_r <= cmd.out_kind;
      case (cmd.out_kind)
        cllm_pkg::ST_CREATED, cllm_pkg::ST_INSERTED: begin
          out_idx_r  <= IDX_W'(new_r);
          out_byte_r <= '0;
          out_last_r <= 1'b1;
        end
        cllm_pkg::ST_ELEMENT: begin
          out_idx_r  <= IDX_W'(cur_r);
          out_byte_r <= elem_q;
          out_last_r <= sts.elem_last;
        end
        cllm_pkg::ST_EMPTY: begin
          out_idx_r  <= IDX_W'(head_r);
          out_byte_r <= '0;
          out_last_r <= 1'b1;
        end
        default: begin
          out_idx_r  <= '0;
          out_byte_r <= '0;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign sts.func      = func_r;
  assign sts.head_oor  = (32'(head_r) >= 32'(NODES));
  assign sts.free_null = (free_head_r >= NULL_LINK);
  assign sts.rd_null   = rd_null;
  assign sts.elem_last = rd_null || ((count_r + CW'(1)) == CW'(CAP));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_idx_r;
  assign out_elem_byte  = out_byte_r;
  assign out_last       = out_last_r;

endmodule

### sv/cllm_ctrl.sv
// controller: sequences create, insert and read over the node store
module cllm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cllm_pkg::sts_t sts,
  output cllm_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_DECODE    = 11'b00000000010,
    S_C_POP     = 11'b00000000100,
    S_I_POP     = 11'b00000001000,
    S_I_LINK    = 11'b00000010000,
    S_I_HEAD    = 11'b00000100000,
    S_R_HEAD    = 11'b00001000000,
    S_R_FETCH   = 11'b00010000000,
    S_EMIT_FULL = 11'b00100000000,
    S_EMIT_DONE = 11'b01000000000,
    S_EMIT_EMPT = 11'b10000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = cllm_pkg::RD_FREE;
    cmd.wr_sel    = cllm_pkg::WR_NEW_NULL;
    cmd.out_kind  = cllm_pkg::ST_FULL;
    cmd.cap_in    = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          cllm_pkg::FN_CREATE: begin
            if (sts.free_null) begin
              state_nxt = S_EMIT_FULL;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = cllm_pkg::RD_FREE;
              cmd.new_ld = 1'b1;
              state_nxt  = S_C_POP;
            end
          end
          cllm_pkg::FN_INSERT: begin
            if (sts.head_oor || sts.free_null) begin
              state_nxt = S_EMIT_FULL;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = cllm_pkg::RD_FREE;
              cmd.new_ld = 1'b1;
              state_nxt  = S_I_POP;
            end
          end
          cllm_pkg::FN_READ: begin
            if (sts.head_oor) begin
              state_nxt = S_EMIT_EMPT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = cllm_pkg::RD_HEAD;
              state_nxt  = S_R_HEAD;
            end
          end
          default: begin
            // unused operation: dropped without a result
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_C_POP: begin
        cmd.free_ld = 1'b1;
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = cllm_pkg::WR_NEW_NULL;
        cmd.out_kind = cllm_pkg::ST_CREATED;
        state_nxt   = S_EMIT_DONE;
      end
      S_I_POP: begin
        cmd.free_ld = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = cllm_pkg::RD_HEAD;
        state_nxt   = S_I_LINK;
      end
      S_I_LINK: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = cllm_pkg::WR_NEW_LINK;
        cmd.elem_we = 1'b1;
        state_nxt   = S_I_HEAD;
      end
      S_I_HEAD: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = cllm_pkg::WR_HEAD_NEW;
        state_nxt  = S_EMIT_DONE;
      end
      S_R_HEAD: begin
        if (sts.rd_null) begin
          state_nxt = S_EMIT_EMPT;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = cllm_pkg::RD_LINK;
          cmd.cur_ld    = 1'b1;
          cmd.count_clr = 1'b1;
          state_nxt     = S_R_FETCH;
        end
      end
      S_R_FETCH: begin
        // element data and its successor link are in the read register
        cmd.out_kind = cllm_pkg::ST_ELEMENT;
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          if (sts.elem_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = cllm_pkg::RD_LINK;
            cmd.cur_ld    = 1'b1;
            cmd.count_inc = 1'b1;
          end
        end
      end
      S_EMIT_FULL: begin
        cmd.out_kind = cllm_pkg::ST_FULL;
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT_DONE: begin
        cmd.out_kind = (sts.func == cllm_pkg::FN_CREATE) ? cllm_pkg::ST_CREATED
                                                         : cllm_pkg::ST_INSERTED;
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT_EMPT: begin
        cmd.out_kind = cllm_pkg::ST_EMPTY;
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/cursor_linked_list_manager_unit.sv
// one operation at a time; create pops a free node, insert also links it in;
// a read fetches the head entry, then emits one element per cycle while
// the result side keeps up, the node store read port setting that pace
// results leave through a register, so a result may wait while the next op decodes
// reset (synchronous, rst_n low) chains all nodes into the free list at once
// through per-node valid bits; stored bytes are not cleared
module cursor_linked_list_manager_unit #(
  parameter int NODES = cllm_pkg::NODES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  cllm_in_if.sink        in_ch,
  cllm_out_if.source     out_ch
);

  cllm_pkg::cmd_t cmd;
  cllm_pkg::sts_t sts;

  cllm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cllm_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_ch.func),
    .in_list_head   (in_ch.list_head),
    .in_data_byte   (in_ch.data_byte),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_node_index (out_ch.node_index),
    .out_elem_byte  (out_ch.elem_byte),
    .out_last       (out_ch.last)
  );

endmodule
